FILE: hw/rtl/kwl_pkg.sv
package kwl_pkg;

  // byte position width and keyword table geometry
  localparam int OFFSET_BITS       = 32;
  localparam int OUT_OFFSET_BITS   = 32;
  localparam int KW_MAX_BYTES      = 32;
  localparam int KW_IDX_W          = $clog2(KW_MAX_BYTES);
  localparam int KW_COUNT          = 7;
  localparam int KW_ROW_BITS       = KW_MAX_BYTES * 8;

  // result queue depth
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

  // clip limits
  localparam logic [7:0] LEN_LIMIT_MAX     = 8'd250;
  localparam logic [7:0] TEXT_LEN_RESET    = 8'd250;
  localparam logic [7:0] NUMBER_LEN_RESET  = 8'd20;
  localparam logic [7:0] LEN_COUNT_MAX     = 8'd255;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEXT_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NUMBER_LEN = 1'd1;

  typedef enum logic [3:0] {
    KIND_PRINT  = 4'd0,
    KIND_INT    = 4'd1,
    KIND_FLOAT  = 4'd2,
    KIND_IF     = 4'd3,
    KIND_FOR    = 4'd4,
    KIND_FUNC   = 4'd5,
    KIND_RETURN = 4'd6,
    KIND_STRING = 4'd7,
    KIND_NUMBER = 4'd8,
    KIND_IDENT  = 4'd9,
    KIND_LPAREN = 4'd10,
    KIND_RPAREN = 4'd11,
    KIND_LBRACE = 4'd12,
    KIND_RBRACE = 4'd13,
    KIND_SEMI   = 4'd14,
    KIND_END    = 4'd15
  } token_kind_t;

  typedef struct packed {
    token_kind_t                 token_kind;
    logic [OUT_OFFSET_BITS-1:0]  start_offset;
    logic [7:0]                  token_length;
    logic                        last_of_run;
  } token_t;

  // keyword byte lengths
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd24, 8'd12, 8'd9, 8'd15, 8'd15, 8'd27, 8'd21
  };

  // keyword bytes, first byte in the top byte lane, zero padded
  localparam logic [KW_ROW_BITS-1:0] KW_ROWS [KW_COUNT] = '{
    {192'hE18095_E180AF_E180B6_E18094_E180BE_E180AD_E18095_E180BA,
     {(KW_ROW_BITS-192){1'b0}}},
    {96'hE180A1_E18090_E1808A_E180BA, {(KW_ROW_BITS-96){1'b0}}},
    {72'hE18092_E18085_E180BA, {(KW_ROW_BITS-72){1'b0}}},
    {120'hE180A1_E18080_E1809A_E180BA_E1818D, {(KW_ROW_BITS-120){1'b0}}},
    {120'hE180A1_E18090_E180BD_E18080_E180BA, {(KW_ROW_BITS-120){1'b0}}},
    {216'hE180A1_E18093_E180AD_E18095_E180B9_E18095_E180AC_E1809A_E180BA,
     {(KW_ROW_BITS-216){1'b0}}},
    {168'hE18095_E180BC_E18094_E180BA_E18095_E180B1_E180B8,
     {(KW_ROW_BITS-168){1'b0}}}
  };

  // one keyword byte at a position
  function automatic logic [7:0] kw_byte(input int k, input logic [KW_IDX_W-1:0] idx);
    logic [KW_ROW_BITS-1:0] row;
    row = KW_ROWS[k];
    return row[(KW_MAX_BYTES - 1 - int'(idx)) * 8 +: 8];
  endfunction

endpackage

FILE: hw/rtl/kwl_byte_if.sv
interface kwl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink   (input valid, input source_byte, output ready);
endinterface

FILE: hw/rtl/kwl_token_if.sv
interface kwl_token_if;
  logic                                  valid;
  logic                                  ready;
  kwl_pkg::token_kind_t                  token_kind;
  logic [kwl_pkg::OUT_OFFSET_BITS-1:0]   start_offset;
  logic [7:0]                            token_length;
  logic                                  last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input last_of_run, output ready);
endinterface

FILE: hw/rtl/keyword_token_lexer_unit.sv
// Streaming lexer: takes one source byte per cycle on in_byte (a zero byte ends
// the source) and returns tokens on out_tok, each with kind, start offset,
// clipped length and a flag on the last token caused by a byte. A byte is
// registered on entry and lexed by one pass of logic that updates the mode,
// offsets, length counter and seven keyword match flags, pushing zero, one or
// two tokens into a four-entry result queue that drives out_tok. With the
// output taking a token every cycle the block takes one byte per cycle; a byte
// is lexed only while the queue has room for two tokens, so bytes that yield
// two tokens each slow the input to the output rate. Clip limits are written
// on the cfg port (index 0 text and word limit, index 1 digit-run limit) by
// the user only while the block is idle (not enforced); there is no read-back.
module keyword_token_lexer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  kwl_byte_if.sink                           in_byte,
  kwl_token_if.source                        out_tok,
  input  logic                               cfg_we,
  input  logic [kwl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_wdata
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STRING  = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_WORD    = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_SLASH   = 3'd5
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_USCR  = 8'h5F;

  // character classes
  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return b[7] || is_alpha(b) || is_digit(b) || (b == CH_USCR);
  endfunction

  // saturating counters
  function automatic logic [7:0] len_inc(input logic [7:0] n);
    return (n != kwl_pkg::LEN_COUNT_MAX) ? n + 8'd1 : n;
  endfunction

  function automatic logic [kwl_pkg::OFFSET_BITS-1:0] pos_inc(
    input logic [kwl_pkg::OFFSET_BITS-1:0] p);
    return (p != '1) ? p + kwl_pkg::OFFSET_BITS'(1) : p;
  endfunction

  // offset as reported, saturated to the output width
  function automatic logic [kwl_pkg::OUT_OFFSET_BITS-1:0] out_offset(
    input logic [kwl_pkg::OFFSET_BITS-1:0] p);
    logic [kwl_pkg::OFFSET_BITS+kwl_pkg::OUT_OFFSET_BITS-1:0] wide;
    wide = {{kwl_pkg::OUT_OFFSET_BITS{1'b0}}, p};
    if ((wide >> kwl_pkg::OUT_OFFSET_BITS) != '0) begin
      return '1;
    end
    return wide[kwl_pkg::OUT_OFFSET_BITS-1:0];
  endfunction

  // length clipped to a limit, zero limit acting as one
  function automatic logic [7:0] clip(input logic [7:0] n, input logic [7:0] limit);
    logic [7:0] eff;
    eff = (limit == 8'd0) ? 8'd1 :
          (limit > kwl_pkg::LEN_LIMIT_MAX) ? kwl_pkg::LEN_LIMIT_MAX : limit;
    return (n > eff) ? eff : n;
  endfunction

  // drop keywords that disagree with this byte at this position
  function automatic logic [kwl_pkg::KW_COUNT-1:0] kw_match(
    input logic [kwl_pkg::KW_COUNT-1:0] flags, input logic [7:0] n, input logic [7:0] b);
    logic [kwl_pkg::KW_COUNT-1:0] f;
    f = flags;
    for (int k = 0; k < kwl_pkg::KW_COUNT; k++) begin
      if ((n >= kwl_pkg::KW_LEN[k]) ||
          (kwl_pkg::kw_byte(k, n[kwl_pkg::KW_IDX_W-1:0]) != b)) begin
        f[k] = 1'b0;
      end
    end
    return f;
  endfunction

  // kind of a finished word
  function automatic kwl_pkg::token_kind_t word_kind(
    input logic [kwl_pkg::KW_COUNT-1:0] flags, input logic [7:0] n);
    kwl_pkg::token_kind_t kind;
    kind = kwl_pkg::KIND_IDENT;
    for (int k = kwl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (flags[k] && (n == kwl_pkg::KW_LEN[k])) begin
        kind = kwl_pkg::token_kind_t'(4'(k));
      end
    end
    return kind;
  endfunction

  // registers
  mode_t                              mode_r, mode_nxt;
  logic [kwl_pkg::OFFSET_BITS-1:0]    pos_r, pos_nxt;
  logic [kwl_pkg::OFFSET_BITS-1:0]    start_r, start_nxt;
  logic [7:0]                         len_r, len_nxt;
  logic [kwl_pkg::KW_COUNT-1:0]       flags_r, flags_nxt;
  logic [7:0]                         text_lim_r, num_lim_r;
  logic                               vld_r;
  logic [7:0]                         byte_r;
  logic [kwl_pkg::FIFO_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [kwl_pkg::FIFO_PTR_W-1:0]     wr_r, rd_r;
  kwl_pkg::token_t                    fifo_r [kwl_pkg::FIFO_DEPTH];

  // lexer pass signals
  logic                               proc;
  logic                               pop;
  logic                               run_idle;
  logic                               idle_emit;
  kwl_pkg::token_t                    tok_idle;
  kwl_pkg::token_t                    tok [2];
  logic [1:0]                         n_tok;
  logic [7:0]                         b;

  // byte is lexed when the queue can take two tokens
  assign proc = vld_r && (cnt_r <= kwl_pkg::FIFO_CNT_W'(kwl_pkg::FIFO_DEPTH - 2));
  assign pop  = out_tok.valid && out_tok.ready;
  assign in_byte.ready = !vld_r || proc;
  assign b = byte_r;

  // one lexing pass over the registered byte
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    flags_nxt = flags_r;
    tok[0]    = '0;
    tok[1]    = '0;
    tok_idle  = '0;
    n_tok     = 2'd0;
    run_idle  = 1'b0;
    idle_emit = 1'b0;

    // mode specific handling
    case (mode_r)
      MODE_STRING: begin
        if (b == CH_QUOTE || b == CH_NUL) begin
          tok[0] = '{kwl_pkg::KIND_STRING, out_offset(start_r),
                     clip(len_r, text_lim_r), 1'b0};
          n_tok  = 2'd1;
          mode_nxt = MODE_IDLE;
          run_idle = (b == CH_NUL);
        end else begin
          len_nxt = len_inc(len_r);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NL) begin
          mode_nxt = MODE_IDLE;
        end else if (b == CH_NUL) begin
          run_idle = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_nxt = MODE_COMMENT;
        end else begin
          run_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(b)) begin
          len_nxt = len_inc(len_r);
        end else begin
          tok[0] = '{kwl_pkg::KIND_NUMBER, out_offset(start_r),
                     clip(len_r, num_lim_r), 1'b0};
          n_tok  = 2'd1;
          run_idle = 1'b1;
        end
      end
      MODE_WORD: begin
        if (b != CH_NUL && is_word(b)) begin
          flags_nxt = kw_match(flags_r, len_r, b);
          len_nxt   = len_inc(len_r);
        end else begin
          tok[0] = '{word_kind(flags_r, len_r), out_offset(start_r),
                     clip(len_r, text_lim_r), 1'b0};
          n_tok  = 2'd1;
          run_idle = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // byte handled from idle
    if (run_idle) begin
      mode_nxt = MODE_IDLE;
      tok_idle.start_offset = out_offset(pos_r);
      tok_idle.token_length = 8'd1;
      if (b == CH_NUL) begin
        tok_idle.token_kind   = kwl_pkg::KIND_END;
        tok_idle.token_length = 8'd0;
        idle_emit = 1'b1;
      end else if (is_space(b)) begin
        mode_nxt = MODE_IDLE;
      end else if (b == CH_HASH) begin
        mode_nxt = MODE_COMMENT;
      end else if (b == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
      end else if (b == CH_QUOTE) begin
        mode_nxt  = MODE_STRING;
        start_nxt = pos_inc(pos_r);
        len_nxt   = 8'd0;
      end else if (is_digit(b)) begin
        mode_nxt  = MODE_NUMBER;
        start_nxt = pos_r;
        len_nxt   = 8'd1;
      end else if (b == CH_LPAR) begin
        tok_idle.token_kind = kwl_pkg::KIND_LPAREN;
        idle_emit = 1'b1;
      end else if (b == CH_RPAR) begin
        tok_idle.token_kind = kwl_pkg::KIND_RPAREN;
        idle_emit = 1'b1;
      end else if (b == CH_LBRC) begin
        tok_idle.token_kind = kwl_pkg::KIND_LBRACE;
        idle_emit = 1'b1;
      end else if (b == CH_RBRC) begin
        tok_idle.token_kind = kwl_pkg::KIND_RBRACE;
        idle_emit = 1'b1;
      end else if (b == CH_SEMI) begin
        tok_idle.token_kind = kwl_pkg::KIND_SEMI;
        idle_emit = 1'b1;
      end else if (b[7] || is_alpha(b)) begin
        mode_nxt  = MODE_WORD;
        start_nxt = pos_r;
        len_nxt   = 8'd1;
        flags_nxt = kw_match('1, 8'd0, b);
      end
    end

    // place the idle token after any flushed one
    if (idle_emit) begin
      if (n_tok == 2'd0) begin
        tok[0] = tok_idle;
      end else begin
        tok[1] = tok_idle;
      end
      n_tok = n_tok + 2'd1;
    end

    // mark the last token of this byte
    if (n_tok == 2'd1) begin
      tok[0].last_of_run = 1'b1;
    end else if (n_tok == 2'd2) begin
      tok[1].last_of_run = 1'b1;
    end

    // end of source restarts everything
    if (b == CH_NUL) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = 8'd0;
      flags_nxt = '0;
    end else begin
      pos_nxt = pos_inc(pos_r);
    end
  end

  // queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (proc) begin
      cnt_nxt = cnt_nxt + kwl_pkg::FIFO_CNT_W'(n_tok);
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - kwl_pkg::FIFO_CNT_W'(1);
    end
  end

  // control state, lexer state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      pos_r      <= '0;
      start_r    <= '0;
      len_r      <= 8'd0;
      flags_r    <= '0;
      text_lim_r <= kwl_pkg::TEXT_LEN_RESET;
      num_lim_r  <= kwl_pkg::NUMBER_LEN_RESET;
      vld_r      <= 1'b0;
      cnt_r      <= '0;
      wr_r       <= '0;
      rd_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kwl_pkg::CFG_MAX_TEXT_LEN:   text_lim_r <= cfg_wdata;
          kwl_pkg::CFG_MAX_NUMBER_LEN: num_lim_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_byte.ready) begin
        vld_r <= in_byte.valid;
      end
      if (proc) begin
        mode_r  <= mode_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
        flags_r <= flags_nxt;
        wr_r    <= wr_r + kwl_pkg::FIFO_PTR_W'(n_tok);
      end
      if (pop) begin
        rd_r <= rd_r + kwl_pkg::FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // input byte and queue storage
  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      byte_r <= in_byte.source_byte;
    end
    if (proc && (n_tok != 2'd0)) begin
      fifo_r[wr_r] <= tok[0];
    end
    if (proc && (n_tok == 2'd2)) begin
      fifo_r[wr_r + kwl_pkg::FIFO_PTR_W'(1)] <= tok[1];
    end
  end

  // result channel
  assign out_tok.valid        = (cnt_r != '0);
  assign out_tok.token_kind   = fifo_r[rd_r].token_kind;
  assign out_tok.start_offset = fifo_r[rd_r].start_offset;
  assign out_tok.token_length = fifo_r[rd_r].token_length;
  assign out_tok.last_of_run  = fifo_r[rd_r].last_of_run;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= kwl_pkg::FIFO_CNT_W'(kwl_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // end of source always closes with an end token
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && byte_r == CH_NUL) |->
      ((n_tok == 2'd1 && tok[0].token_kind == kwl_pkg::KIND_END) ||
       (n_tok == 2'd2 && tok[1].token_kind == kwl_pkg::KIND_END)))
    else $error("zero byte without end token");

  // end of source resets position and mode
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && byte_r == CH_NUL) |=> (pos_r == '0 && mode_r == MODE_IDLE))
    else $error("position not restarted after end of source");

  // a result is never popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("result queue underflow");

endmodule

FILE: test/tb_keyword_token_lexer_unit.sv
`timescale 1ns / 1ps

module tb_keyword_token_lexer_unit;

  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  // opening bytes: every mark, a word ended by a quote, zero inside a string,
  // comments of both kinds, a lone slash, a number flushed by zero, bare zero
  localparam logic [7:0] OPENING_BYTES [25] = '{
    "(", ")", "{", "}", ";", " ", "7", "Z", 8'hFF, 8'h22, "_", 8'h00, "/",
    "/", "c", 8'h0A, "#", 8'h09, 8'h0A, "/", "x", " ", "9", 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    LX_IDLE, LX_STRING, LX_NUMBER, LX_WORD, LX_COMMENT, LX_SLASH
  } lex_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [kwl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  kwl_byte_if  in_if ();
  kwl_token_if out_if ();

  keyword_token_lexer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_if),
    .out_tok   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // lexer state mirrored by the testbench
  lex_mode_t   lex_mode = LX_IDLE;
  logic [31:0] byte_pos = '0;
  logic [31:0] tok_start = '0;
  logic [7:0]  len_count = '0;
  logic [6:0]  kw_flags = '0;
  logic [7:0]  text_limit = kwl_pkg::TEXT_LEN_RESET;
  logic [7:0]  number_limit = kwl_pkg::NUMBER_LEN_RESET;

  kwl_pkg::token_t expected_tokens [$];
  int          step_count;
  logic [7:0]  source_bytes [$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          phase_bytes = 0;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  function automatic logic [7:0] keyword_len(input int k);
    case (k)
      0: return 8'd24;
      1: return 8'd12;
      2: return 8'd9;
      3: return 8'd15;
      4: return 8'd15;
      5: return 8'd27;
      default: return 8'd21;
    endcase
  endfunction

  // keyword bytes, first byte leftmost
  function automatic logic [7:0] keyword_byte(input int k, input int n);
    logic [215:0] row;
    case (k)
      0: row = {192'hE18095_E180AF_E180B6_E18094_E180BE_E180AD_E18095_E180BA, 24'h0};
      1: row = {96'hE180A1_E18090_E1808A_E180BA, 120'h0};
      2: row = {72'hE18092_E18085_E180BA, 144'h0};
      3: row = {120'hE180A1_E18080_E1809A_E180BA_E1818D, 96'h0};
      4: row = {120'hE180A1_E18090_E180BD_E18080_E180BA, 96'h0};
      5: row = 216'hE180A1_E18093_E180AD_E18095_E180B9_E18095_E180AC_E1809A_E180BA;
      default: row = {168'hE18095_E180BC_E18094_E180BA_E18095_E180B1_E180B8, 48'h0};
    endcase
    return row[(26 - n) * 8 +: 8];
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [31:0] next_pos(input logic [31:0] p);
    return (p == '1) ? p : p + 32'd1;
  endfunction

  // reported length: counter clipped to the limit, 0 acting as 1, above 250 as 250
  function automatic logic [7:0] clipped_len(input logic [7:0] limit);
    logic [7:0] eff;
    eff = (limit == 8'd0) ? 8'd1 :
          (limit > kwl_pkg::LEN_LIMIT_MAX) ? kwl_pkg::LEN_LIMIT_MAX : limit;
    return (len_count > eff) ? eff : len_count;
  endfunction

  function automatic void push_token(input kwl_pkg::token_kind_t kind,
                                     input logic [31:0] start, input logic [7:0] len);
    kwl_pkg::token_t t;
    t.token_kind   = kind;
    t.start_offset = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
    step_count++;
  endfunction

  // streamed keyword compare on the unclipped word
  function automatic void match_word_byte(input logic [7:0] b);
    for (int k = 0; k < kwl_pkg::KW_COUNT; k++) begin
      if (len_count >= keyword_len(k)) begin
        kw_flags[k] = 1'b0;
      end else if (keyword_byte(k, int'(len_count)) != b) begin
        kw_flags[k] = 1'b0;
      end
    end
    if (len_count != kwl_pkg::LEN_COUNT_MAX) len_count++;
  endfunction

  function automatic void from_idle(input logic [7:0] b);
    lex_mode = LX_IDLE;
    if (b == 8'h00) begin
      push_token(kwl_pkg::KIND_END, byte_pos, 8'd0);
    end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
      // whitespace: nothing to do
    end else if (b == "#") begin
      lex_mode = LX_COMMENT;
    end else if (b == "/") begin
      lex_mode = LX_SLASH;
    end else if (b == 8'h22) begin
      lex_mode  = LX_STRING;
      tok_start = next_pos(byte_pos);
      len_count = 8'd0;
    end else if (is_digit(b)) begin
      lex_mode  = LX_NUMBER;
      tok_start = byte_pos;
      len_count = 8'd1;
    end else if (b == "(") begin
      push_token(kwl_pkg::KIND_LPAREN, byte_pos, 8'd1);
    end else if (b == ")") begin
      push_token(kwl_pkg::KIND_RPAREN, byte_pos, 8'd1);
    end else if (b == "{") begin
      push_token(kwl_pkg::KIND_LBRACE, byte_pos, 8'd1);
    end else if (b == "}") begin
      push_token(kwl_pkg::KIND_RBRACE, byte_pos, 8'd1);
    end else if (b == ";") begin
      push_token(kwl_pkg::KIND_SEMI, byte_pos, 8'd1);
    end else if (b >= 8'h80 || is_letter(b)) begin
      lex_mode  = LX_WORD;
      tok_start = byte_pos;
      len_count = 8'd0;
      kw_flags  = 7'h7F;
      match_word_byte(b);
    end
  endfunction

  // expected tokens for one accepted source byte
  function automatic void lex_byte(input logic [7:0] b);
    kwl_pkg::token_kind_t kind;
    kwl_pkg::token_t last;
    step_count = 0;
    case (lex_mode)
      LX_STRING: begin
        if (b == 8'h22) begin
          push_token(kwl_pkg::KIND_STRING, tok_start, clipped_len(text_limit));
          lex_mode = LX_IDLE;
        end else if (b == 8'h00) begin
          push_token(kwl_pkg::KIND_STRING, tok_start, clipped_len(text_limit));
          from_idle(b);
        end else if (len_count != kwl_pkg::LEN_COUNT_MAX) begin
          len_count++;
        end
      end
      LX_COMMENT: begin
        if (b == 8'h0A) lex_mode = LX_IDLE;
        else if (b == 8'h00) from_idle(b);
      end
      LX_SLASH: begin
        if (b == "/") lex_mode = LX_COMMENT;
        else from_idle(b);
      end
      LX_NUMBER: begin
        if (is_digit(b)) begin
          if (len_count != kwl_pkg::LEN_COUNT_MAX) len_count++;
        end else begin
          push_token(kwl_pkg::KIND_NUMBER, tok_start, clipped_len(number_limit));
          from_idle(b);
        end
      end
      LX_WORD: begin
        if (b != 8'h00 && (b >= 8'h80 || is_letter(b) || is_digit(b) || b == "_")) begin
          match_word_byte(b);
        end else begin
          // lowest numbered keyword of the right length wins
          kind = kwl_pkg::KIND_IDENT;
          for (int k = kwl_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (kw_flags[k] && len_count == keyword_len(k))
              kind = kwl_pkg::token_kind_t'(4'(k));
          end
          push_token(kind, tok_start, clipped_len(text_limit));
          from_idle(b);
        end
      end
      default: from_idle(b);
    endcase
    if (b == 8'h00) begin
      byte_pos  = '0;
      tok_start = '0;
      len_count = '0;
      kw_flags  = '0;
      lex_mode  = LX_IDLE;
    end else begin
      byte_pos = next_pos(byte_pos);
    end
    if (step_count != 0) begin
      last = expected_tokens.pop_back();
      last.last_of_run = 1'b1;
      expected_tokens.push_back(last);
    end
  endfunction

  // source byte generation
  function automatic void put_byte(input logic [7:0] b);
    source_bytes.push_back(b);
    bytes_queued++;
    phase_bytes++;
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_word_byte();
    case ($urandom_range(0, 3))
      0: return rand_letter();
      1: return 8'($urandom_range(48, 57));
      2: return "_";
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_mark();
    case ($urandom_range(0, 4))
      0: return "(";
      1: return ")";
      2: return "{";
      3: return "}";
      default: return ";";
    endcase
  endfunction

  // any byte but zero and the one excluded
  function automatic logic [7:0] rand_byte_except(input logic [7:0] skip);
    logic [7:0] b;
    b = 8'($urandom_range(1, 254));
    if (b >= skip) b++;
    return b;
  endfunction

  // runs longer than the length counter: 0 word, 1 string, 2 digits
  function automatic void add_long_run(input int form);
    case (form)
      0: begin
        put_byte(rand_letter());
        for (int i = 1; i < 260; i++) put_byte(rand_word_byte());
        put_byte(" ");
      end
      1: begin
        put_byte(8'h22);
        for (int i = 0; i < 260; i++) put_byte(rand_byte_except(8'h22));
        put_byte(8'h22);
      end
      default: begin
        for (int i = 0; i < 260; i++) put_byte(8'($urandom_range(48, 57)));
        put_byte(";");
      end
    endcase
  endfunction

  function automatic void add_random_chunk();
    int pick;
    int n;
    int k;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // keyword, exact or a near miss: one short, one extra, last byte changed
      k = $urandom_range(0, kwl_pkg::KW_COUNT - 1);
      v = $urandom_range(0, 3);
      n = int'(keyword_len(k));
      if (v == 1) n--;
      for (int i = 0; i < n; i++) begin
        if (v == 3 && i == n - 1) put_byte(8'($urandom_range(128, 191)));
        else put_byte(keyword_byte(k, i));
      end
      if (v == 2) put_byte(rand_word_byte());
      put_byte($urandom_range(0, 1) ? " " : rand_mark());
    end else if (pick < 34) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      put_byte($urandom_range(0, 1) ? rand_letter() : 8'($urandom_range(128, 255)));
      for (int i = 1; i < n; i++) put_byte(rand_word_byte());
    end else if (pick < 44) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 30) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(48, 57)));
    end else if (pick < 54) begin
      // string, now and then cut off by the end of source
      put_byte(8'h22);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) put_byte(rand_byte_except(8'h22));
      put_byte(($urandom_range(0, 7) == 0) ? 8'h00 : 8'h22);
    end else if (pick < 68) begin
      put_byte(rand_mark());
    end else if (pick < 77) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        put_byte(($urandom_range(0, 5) == 0) ? " " : 8'($urandom_range(9, 13)));
    end else if (pick < 84) begin
      if ($urandom_range(0, 1)) begin
        put_byte("#");
      end else begin
        put_byte("/");
        put_byte("/");
      end
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) put_byte(rand_byte_except(8'h0A));
      put_byte(($urandom_range(0, 5) == 0) ? 8'h00 : 8'h0A);
    end else if (pick < 88) begin
      put_byte("/");
    end else if (pick < 97) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_byte(8'h00);
    end
  endfunction

  task automatic write_reg(input logic [kwl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == kwl_pkg::CFG_MAX_TEXT_LEN) text_limit = value;
    else number_limit = value;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // byte driver, predicting on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid       <= 1'b0;
      in_if.source_byte <= 8'd0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        lex_byte(in_if.source_byte);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (source_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_if.valid       <= 1'b1;
          in_if.source_byte <= source_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // token monitor and output back-pressure
  always @(posedge clk) begin : token_monitor
    kwl_pkg::token_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected token, expected none, actual kind %0d offset %0d len %0d",
                   $time, out_if.token_kind, out_if.start_offset, out_if.token_length);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 32'(want.token_kind), 32'(out_if.token_kind));
          check_field("start_offset", want.start_offset, out_if.start_offset);
          check_field("token_length", 32'(want.token_length), 32'(out_if.token_length));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_if.last_of_run));
        end
      end
      // one long hold-off while the sender keeps offering bytes
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && send_gap_pct == 0 && recv_gap_pct == 0 && in_if.valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] text_value;
    logic [7:0] number_value;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = kwl_pkg::CFG_MAX_TEXT_LEN;
    cfg_wdata = 8'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      send_gap_pct = (ph < 2) ? 25 : (ph < 4) ? 86 : 0;
      recv_gap_pct = (ph < 2) ? 86 : (ph < 4) ? 25 : 0;
      case (ph)
        0: begin text_value = 8'd250; number_value = 8'd20;  end
        1: begin text_value = 8'd1;   number_value = 8'd1;   end
        2: begin text_value = 8'd0;   number_value = 8'd255; end
        3: begin text_value = 8'd5;   number_value = 8'd3;   end
        4: begin text_value = 8'd255; number_value = 8'd250; end
        default: begin
          text_value   = 8'd250;
          number_value = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(kwl_pkg::CFG_MAX_TEXT_LEN, text_value);
      write_reg(kwl_pkg::CFG_MAX_NUMBER_LEN, number_value);

      phase_bytes = 0;
      if (ph == 0) foreach (OPENING_BYTES[i]) put_byte(OPENING_BYTES[i]);
      if (ph == 2) add_long_run(1);
      if (ph == 4) add_long_run(2);
      if (ph == 5) add_long_run(0);
      while (phase_bytes < PHASE_ITEMS) add_random_chunk();
      // close the source so no token stays open across a register write
      put_byte(8'h00);

      while (bytes_taken != bytes_queued || expected_tokens.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: keyword_token_lexer_unit.f
hw/rtl/kwl_pkg.sv
hw/rtl/kwl_byte_if.sv
hw/rtl/kwl_token_if.sv
hw/rtl/keyword_token_lexer_unit.sv
test/tb_keyword_token_lexer_unit.sv
